>>> sv/sqh_pkg.sv
// Shared types, constants and codes for the stack/queue/heap order checker.
package sqh_pkg;
  localparam int unsigned CapacityDefault  = 1024;
  localparam int unsigned ValueBitsDefault = 16;
  localparam int unsigned InValueBits      = 16;
  localparam int unsigned VerdictBits      = 3;

  localparam logic [VerdictBits-1:0] VerdNotSure    = 3'd0;
  localparam logic [VerdictBits-1:0] VerdStack      = 3'd1;
  localparam logic [VerdictBits-1:0] VerdQueue      = 3'd2;
  localparam logic [VerdictBits-1:0] VerdPrio       = 3'd3;
  localparam logic [VerdictBits-1:0] VerdImpossible = 3'd4;

  typedef enum logic [4:0] {
    OP_NONE     = 5'b00001,
    OP_PUSH     = 5'b00010,
    OP_POP_RD   = 5'b00100,
    OP_POP_CHK  = 5'b01000,
    OP_CLEAR    = 5'b10000
  } dp_op_t;

  typedef struct packed {
    logic   start;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_stat_t;
endpackage

>>> sv/sqh_if.sv
// Valid/ready channel interfaces for input operations and verdicts.
interface sqh_in_if #(parameter int unsigned VW = 16) (input logic clk);
  logic          valid;
  logic          ready;
  logic          action;
  logic [VW-1:0] value;
  logic          last_of_case;
  modport source (output valid, action, value, last_of_case, input ready);
  modport sink   (input valid, action, value, last_of_case, output ready);
endinterface

interface sqh_out_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [2:0] verdict;
  logic       overflow;
  modport source (output valid, verdict, overflow, input ready);
  modport sink   (input valid, verdict, overflow, output ready);
endinterface

>>> sv/sqh_ram.sv
// Generic single-port RAM with registered read.
module sqh_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem_r[addr] <= wdata;
    rdata <= mem_r[addr];
  end
endmodule

>>> sv/sqh_datapath.sv
// Datapath: three stores, counters, heap sift engine and model flags.
module sqh_datapath #(
  parameter int unsigned CAPACITY   = 1024,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sqh_pkg::dp_cmd_t       cmd,
  input  logic                   in_action,
  input  logic [VALUE_BITS-1:0]  in_value,
  output sqh_pkg::dp_stat_t      stat,
  output logic [2:0]             verdict,
  output logic                   overflow
);
  import sqh_pkg::*;
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  typedef enum logic [8:0] {
    H_IDLE = 9'b000000001, H_UP_RD = 9'b000000010, H_UP_CMP = 9'b000000100,
    H_DN_LAST = 9'b000001000, H_DN_LW = 9'b000010000, H_DN_RC1 = 9'b000100000,
    H_DN_RC2 = 9'b001000000, H_DN_CMP = 9'b010000000, H_WR = 9'b100000000
  } hst_t;

  logic [VALUE_BITS-1:0] v_r, hv_r, c1_r;
  logic [CW-1:0] live_r, hi_r, hsz_r, hc_r;
  logic [AW-1:0] head_r, tail_r;
  logic s_ok_r, f_ok_r, h_ok_r, stop_r, ovf_r;
  hst_t hst_r;
  logic chk_r;

  logic s_we, f_we, h_we;
  logic [AW-1:0] s_a, f_a, h_a;
  logic [VALUE_BITS-1:0] h_wd, s_rd, f_rd, h_rd;

  sqh_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_stk (
    .clk, .we(s_we), .addr(s_a), .wdata(in_value), .rdata(s_rd));
  sqh_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_ring (
    .clk, .we(f_we), .addr(f_a), .wdata(in_value), .rdata(f_rd));
  sqh_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_heap (
    .clk, .we(h_we), .addr(h_a), .wdata(h_wd), .rdata(h_rd));

  logic push_go, pop_rd;
  logic [CW-1:0] par, c1, c2;
  logic [CW-1:0] live_m1;
  assign push_go = cmd.start && cmd.op == OP_PUSH;
  assign pop_rd  = cmd.start && cmd.op == OP_POP_RD;
  assign par     = (hi_r - CW'(1)) >> 1;
  assign c1      = {hi_r[CW-2:0], 1'b1};
  assign c2      = c1 + CW'(1);
  assign live_m1 = live_r - CW'(1);

  always_comb begin
    s_we = 1'b0; f_we = 1'b0; h_we = 1'b0;
    s_a = live_m1[AW-1:0]; f_a = head_r; h_a = '0; h_wd = hv_r;
    case (hst_r)
      H_IDLE: begin
        if (push_go && !stop_r && live_r < CapC) begin
          s_a = live_r[AW-1:0]; s_we = s_ok_r;
          f_a = tail_r; f_we = f_ok_r;
        end
      end
      H_UP_RD:   h_a = par[AW-1:0];
      H_DN_LAST: h_a = hsz_r[AW-1:0];
      H_DN_RC1:  h_a = c1[AW-1:0];
      H_DN_RC2:  h_a = c2[AW-1:0];
      H_UP_CMP: begin
        if (h_rd < hv_r) begin
          h_a = hi_r[AW-1:0]; h_we = 1'b1; h_wd = h_rd;
        end
      end
      H_DN_CMP: begin
        h_a = hi_r[AW-1:0];
        if (c1_r > hv_r || (hc_r != c1 && h_rd > hv_r)) begin
          h_we = 1'b1;
          h_wd = (hc_r != c1 && h_rd > c1_r) ? h_rd : c1_r;
        end
      end
      H_WR: begin
        h_a = hi_r[AW-1:0]; h_we = 1'b1;
      end
      default: ;
    endcase
  end

  logic s_m, f_m, h_m, any_m;
  assign s_m = s_ok_r && s_rd == v_r;
  assign f_m = f_ok_r && f_rd == v_r;
  assign h_m = h_ok_r && h_rd == v_r;
  assign any_m = s_m || f_m || h_m;

  always_ff @(posedge clk) begin
    if (!rst_n || (cmd.start && cmd.op == OP_CLEAR)) begin
      live_r <= '0; head_r <= '0; tail_r <= '0;
      s_ok_r <= 1'b1; f_ok_r <= 1'b1; h_ok_r <= 1'b1;
      stop_r <= 1'b0; ovf_r <= 1'b0; hst_r <= H_IDLE; chk_r <= 1'b0;
    end else begin
      chk_r <= pop_rd && !stop_r && live_r != '0;
      case (hst_r)
        H_IDLE: begin
          if (push_go && !stop_r) begin
            if (live_r >= CapC) begin
              ovf_r <= 1'b1; stop_r <= 1'b1;
              s_ok_r <= 1'b0; f_ok_r <= 1'b0; h_ok_r <= 1'b0;
            end else begin
              live_r <= live_r + CW'(1);
              if (f_ok_r) tail_r <= (tail_r == AW'(CAPACITY - 1)) ? '0 : tail_r + AW'(1);
              hi_r <= live_r; hv_r <= in_value;
              if (h_ok_r) hst_r <= (live_r == '0) ? H_WR : H_UP_RD;
            end
          end else if (pop_rd && !stop_r && live_r == '0) begin
            stop_r <= 1'b1; s_ok_r <= 1'b0; f_ok_r <= 1'b0; h_ok_r <= 1'b0;
          end else if (chk_r) begin
            if (s_ok_r && !s_m) s_ok_r <= 1'b0;
            if (f_ok_r) begin
              if (!f_m) f_ok_r <= 1'b0;
              else head_r <= (head_r == AW'(CAPACITY - 1)) ? '0 : head_r + AW'(1);
            end
            if (h_ok_r && !h_m) h_ok_r <= 1'b0;
            if (any_m) live_r <= live_m1; else stop_r <= 1'b1;
            hsz_r <= live_m1; hi_r <= '0;
            if (h_m && live_m1 != '0) hst_r <= H_DN_LAST;
          end
        end
        H_UP_RD: hst_r <= H_UP_CMP;
        H_UP_CMP: begin
          if (h_rd < hv_r) begin
            hi_r <= par;
            hst_r <= (par == '0) ? H_WR : H_UP_RD;
          end else hst_r <= H_WR;
        end
        H_DN_LAST: hst_r <= H_DN_LW;
        H_DN_LW: begin
          hv_r <= h_rd;
          hst_r <= (c1 >= hsz_r) ? H_WR : H_DN_RC1;
        end
        H_DN_RC1: begin
          hc_r <= (c2 < hsz_r) ? c2 : c1;
          hst_r <= H_DN_RC2;
        end
        H_DN_RC2: begin
          c1_r <= h_rd; hst_r <= H_DN_CMP;
        end
        H_DN_CMP: begin
          if (c1_r > hv_r || (hc_r != c1 && h_rd > hv_r)) begin
            if (hc_r != c1 && h_rd > c1_r) begin
              hi_r <= c2; hst_r <= ({c2[CW-2:0], 1'b1} >= hsz_r) ? H_WR : H_DN_RC1;
            end else begin
              hi_r <= c1; hst_r <= ({c1[CW-2:0], 1'b1} >= hsz_r) ? H_WR : H_DN_RC1;
            end
          end else hst_r <= H_WR;
        end
        H_WR: hst_r <= H_IDLE;
        default: hst_r <= H_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start && cmd.op != OP_CLEAR) v_r <= in_value;
  end

  logic [1:0] alive;
  assign alive = 2'(s_ok_r) + 2'(f_ok_r) + 2'(h_ok_r);
  always_comb begin
    if (alive >= 2'd2) verdict = VerdNotSure;
    else if (s_ok_r)   verdict = VerdStack;
    else if (f_ok_r)   verdict = VerdQueue;
    else if (h_ok_r)   verdict = VerdPrio;
    else               verdict = VerdImpossible;
  end
  assign overflow  = ovf_r;
  assign stat.done = hst_r == H_IDLE && !cmd.start && !chk_r && !in_action;
endmodule

>>> sv/sqh_ctrl.sv
// Controller: input handshake, operation sequencing and verdict output.
module sqh_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output sqh_pkg::dp_cmd_t   cmd,
  input  sqh_pkg::dp_stat_t  stat
);
  import sqh_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_BUSY = 4'b0010, S_EMIT = 4'b0100, S_CLR = 4'b1000
  } st_t;
  st_t st_r, st_nxt;
  logic last_r, last_nxt;

  assign in_ready  = st_r == S_IDLE;
  assign out_valid = st_r == S_EMIT;

  always_comb begin
    st_nxt = st_r; last_nxt = last_r;
    cmd.start = 1'b0; cmd.op = OP_NONE;
    case (st_r)
      S_IDLE: if (in_valid) begin
        cmd.start = 1'b1; cmd.op = in_action ? OP_PUSH : OP_POP_RD;
        last_nxt = in_last; st_nxt = S_BUSY;
      end
      S_BUSY: if (stat.done) st_nxt = last_r ? S_EMIT : S_IDLE;
      S_EMIT: if (out_ready) st_nxt = S_CLR;
      S_CLR: begin
        cmd.start = 1'b1; cmd.op = OP_CLEAR; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; last_r <= 1'b0;
    end else begin
      st_r <= st_nxt; last_r <= last_nxt;
    end
  end
endmodule

>>> sv/stack_queue_heap_order_checker.sv
// Top level of the stack/queue/heap order checker.
// One operation at a time: a new one is taken only when the last is done, heap sift over the single RAM port included.
// A last operation adds the verdict transfer and then a clear state.
// Synchronous active-low reset clears all control state; stores need no clearing.
module stack_queue_heap_order_checker #(
  parameter int unsigned CAPACITY   = sqh_pkg::CapacityDefault,
  parameter int unsigned VALUE_BITS = sqh_pkg::ValueBitsDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  sqh_in_if.sink    in_ch,
  sqh_out_if.source out_ch
);
  import sqh_pkg::*;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [VALUE_BITS-1:0] val;
  assign val = in_ch.value[VALUE_BITS-1:0];

  sqh_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_action(in_ch.action), .in_last(in_ch.last_of_case),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .cmd, .stat);

  sqh_datapath #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk, .rst_n, .cmd, .in_action(1'b0), .in_value(val), .stat,
    .verdict(out_ch.verdict), .overflow(out_ch.overflow));

`ifndef SYNTHESIS
  a_ready_out: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("ready during verdict");
  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("verdict dropped");
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready) else $error("double accept");
`endif
endmodule

>>> sim/stack_queue_heap_order_checker_tb.sv
// Testbench for the stack/queue/heap order checker: directed and random cases, verdicts checked in order.
`timescale 1ns / 100ps
module stack_queue_heap_order_checker_tb;
  import sqh_pkg::*;

  localparam int Cap = 1024;
  localparam int RandItems = 1950;

  typedef struct packed {
    logic        action;
    logic [15:0] value;
    logic        last;
  } op_item_t;

  typedef struct packed {
    logic [2:0] verdict;
    logic       overflow;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sqh_in_if  #(.VW(16)) in_ch (clk);
  sqh_out_if out_ch (clk);

  stack_queue_heap_order_checker dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  op_item_t pending_ops[$];
  verdict_t verdicts_due[$];
  int       errors = 0;
  int       accepted = 0;
  int       total_ops = 0;
  bit       quiet = 1'b0;
  bit       in_taken = 1'b0;
  int       in_gap = 0;
  int       out_gap = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;

  // order model state
  logic [15:0] stk_mem[Cap];
  logic [15:0] ring_mem[Cap];
  logic [15:0] heap_mem[Cap];
  int          live;
  int          head;
  int          tail;
  bit          stk_ok, fifo_ok, heap_ok, stopped, ovf;

  function automatic void clear_order_state();
    live = 0; head = 0; tail = 0;
    stk_ok = 1; fifo_ok = 1; heap_ok = 1; stopped = 0; ovf = 0;
  endfunction

  function automatic void heap_push(logic [15:0] v, int n);
    int i;
    int p;
    i = n;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (heap_mem[p] >= v) break;
      heap_mem[i] = heap_mem[p];
      i = p;
    end
    heap_mem[i] = v;
  endfunction

  function automatic void heap_drop_root(int n);
    int sz;
    int i;
    int c;
    logic [15:0] v;
    sz = n - 1;
    i = 0;
    if (sz == 0) return;
    v = heap_mem[sz];
    forever begin
      c = 2 * i + 1;
      if (c >= sz) break;
      if (c + 1 < sz && heap_mem[c + 1] > heap_mem[c]) c++;
      if (heap_mem[c] <= v) break;
      heap_mem[i] = heap_mem[c];
      i = c;
    end
    heap_mem[i] = v;
  endfunction

  function automatic void stop_case();
    stk_ok = 0; fifo_ok = 0; heap_ok = 0; stopped = 1;
  endfunction

  function automatic void apply_order_op(op_item_t op);
    bit hit;
    int alive;
    verdict_t r;
    if (!stopped) begin
      if (op.action) begin
        if (live >= Cap) begin
          ovf = 1;
          stop_case();
        end else begin
          if (stk_ok) stk_mem[live] = op.value;
          if (fifo_ok) begin
            ring_mem[tail] = op.value;
            tail = (tail + 1) % Cap;
          end
          if (heap_ok) heap_push(op.value, live);
          live++;
        end
      end else if (live == 0) begin
        stop_case();
      end else begin
        hit = 0;
        if (stk_ok) begin
          if (stk_mem[live - 1] != op.value) stk_ok = 0;
          else hit = 1;
        end
        if (fifo_ok) begin
          if (ring_mem[head] != op.value) fifo_ok = 0;
          else begin
            head = (head + 1) % Cap;
            hit = 1;
          end
        end
        if (heap_ok) begin
          if (heap_mem[0] != op.value) heap_ok = 0;
          else begin
            heap_drop_root(live);
            hit = 1;
          end
        end
        if (hit) live--;
        else stopped = 1;
      end
    end
    if (op.last) begin
      alive = stk_ok + fifo_ok + heap_ok;
      if (alive >= 2) r.verdict = VerdNotSure;
      else if (stk_ok) r.verdict = VerdStack;
      else if (fifo_ok) r.verdict = VerdQueue;
      else if (heap_ok) r.verdict = VerdPrio;
      else r.verdict = VerdImpossible;
      r.overflow = ovf;
      verdicts_due.insert(verdicts_due.size(), r);
      clear_order_state();
    end
  endfunction

  function automatic void add_op(bit a, logic [15:0] v, bit l);
    op_item_t op;
    op.action = a; op.value = v; op.last = l;
    pending_ops.insert(pending_ops.size(), op);
    total_ops++;
  endfunction

  // kind: 0 stack, 1 queue, 2 heap, 3 random noise
  function automatic void add_case(int kind, int nops, bit sloppy);
    logic [15:0] held[$];
    logic [15:0] v;
    bit narrow;
    int k;
    int best;
    narrow = ($urandom_range(0, 1) == 0);
    for (int i = 0; i < nops; i++) begin
      if (kind == 3) begin
        add_op(1'($urandom_range(0, 1)), 16'($urandom), i == nops - 1);
        continue;
      end
      if (held.size() == 0 || $urandom_range(0, 1) == 0) begin
        v = narrow ? 16'($urandom_range(0, 3)) : 16'($urandom);
        held.insert(held.size(), v);
        add_op(1'b1, v, i == nops - 1);
      end else begin
        if (kind == 0) k = held.size() - 1;
        else if (kind == 1) k = 0;
        else begin
          best = 0;
          foreach (held[j]) if (held[j] > held[best]) best = j;
          k = best;
        end
        v = held[k];
        held.delete(k);
        if (sloppy && $urandom_range(0, 7) == 0) v = 16'($urandom);
        add_op(1'b0, v, i == nops - 1);
      end
    end
  endfunction

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      in_taken = 1'b0;
      if (in_gap == 0 && !quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 7);
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        op_item_t op;
        op = pending_ops.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.action       <= op.action;
        in_ch.value        <= op.value;
        in_ch.last_of_case <= op.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && accepted > 600) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_ch.ready <= 1'b0;
    end else begin
      if (out_gap == 0 && !quiet && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 7);
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // transfer monitors
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      op_item_t op;
      op.action = in_ch.action;
      op.value  = in_ch.value;
      op.last   = in_ch.last_of_case;
      apply_order_op(op);
      in_taken = 1'b1;
      accepted++;
      if (total_ops - accepted < 200) quiet = 1'b1;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        $error("unexpected verdict transfer: verdict %0d overflow %0d",
               out_ch.verdict, out_ch.overflow);
        errors++;
      end else begin
        want = verdicts_due.pop_front();
        if (out_ch.verdict !== want.verdict) begin
          $error("verdict: expected %0d, actual %0d", want.verdict, out_ch.verdict);
          errors++;
        end
        if (out_ch.overflow !== want.overflow) begin
          $error("overflow: expected %0d, actual %0d", want.overflow, out_ch.overflow);
          errors++;
        end
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = 1'b0;
    in_ch.value = '0;
    in_ch.last_of_case = 1'b0;
    out_ch.ready = 1'b0;
    clear_order_state();

    add_op(1'b1, 16'h0000, 1'b1);
    add_op(1'b1, 16'hFFFF, 1'b0);
    add_op(1'b0, 16'hFFFF, 1'b1);
    add_op(1'b0, 16'h0000, 1'b1);
    add_op(1'b0, 16'h1234, 1'b0);
    add_op(1'b1, 16'h0001, 1'b1);
    add_op(1'b1, 16'd1, 1'b0); add_op(1'b1, 16'd2, 1'b0);
    add_op(1'b0, 16'd2, 1'b0); add_op(1'b0, 16'd1, 1'b1);
    add_op(1'b1, 16'd1, 1'b0); add_op(1'b1, 16'd2, 1'b0);
    add_op(1'b0, 16'd1, 1'b0); add_op(1'b0, 16'd2, 1'b1);
    add_op(1'b1, 16'd3, 1'b0); add_op(1'b1, 16'd1, 1'b0); add_op(1'b1, 16'd2, 1'b0);
    add_op(1'b0, 16'd3, 1'b0); add_op(1'b0, 16'd2, 1'b1);
    add_op(1'b1, 16'd5, 1'b0); add_op(1'b0, 16'd6, 1'b0); add_op(1'b0, 16'd5, 1'b1);
    for (int i = 0; i <= Cap + 1; i++) add_op(1'b1, 16'($urandom), i == Cap + 1);

    while (total_ops < RandItems - 300) begin
      int kind;
      kind = $urandom_range(0, 9);
      if (kind >= 8) add_case(3, $urandom_range(1, 8), 1'b0);
      else add_case(kind % 3, $urandom_range(1, 14), $urandom_range(0, 3) == 0);
    end
    add_case(2, 300, 1'b0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    wait (accepted == total_ops);
    wait (verdicts_due.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #40ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
